// ===== design/kflt_pkg.sv =====
// ---------------------------------------------------------------------------
// kflt_pkg: shared types and constants for the keyframe interpolation table
// Holds the command codes, field widths and the key record layout.
// ---------------------------------------------------------------------------
package kflt_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned POS_W  = 32;
  localparam int unsigned ROT_W  = 16;
  localparam int unsigned BONE_W = 6;
  localparam int unsigned FRAC_W = 16;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // One stored key: time, three positions, four rotations.
  typedef struct packed {
    logic [ROT_W-1:0]  rot_w;
    logic [ROT_W-1:0]  rot_z;
    logic [ROT_W-1:0]  rot_y;
    logic [ROT_W-1:0]  rot_x;
    logic [POS_W-1:0]  pos_z;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_x;
    logic [TIME_W-1:0] tval;
  } key_t;

  // Request to the divide unit and its status back.
  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] num;
    logic [TIME_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [FRAC_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== design/keyframe_lerp_table_core.sv =====
// ---------------------------------------------------------------------------
// keyframe_lerp_table_core: keyframe table with linear interpolation
// Top level: key store, scan sequencer, divider and lerp unit.
// ---------------------------------------------------------------------------
// Clear and append beats are taken in S_IDLE and can follow back to back. A
// query walks the key table with a read state and a compare state per key
// until it reaches the bone's later key, then fetches the earlier key, runs
// the serial divider, makes seven passes of the shared lerp unit and loads
// the output register. Without an earlier key the divider is skipped; a
// query that finds no later key, or whose bone is at or above the limit,
// goes straight to the output register. The block is not ready while a
// query runs. A finished result waits in the output register, so later
// beats are taken while it is held; the next query waits in S_OUT until
// that result is taken.
module keyframe_lerp_table_core #(
  parameter int unsigned MAX_KEYS      = 1024,
  parameter int unsigned BONE_ID_LIMIT = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // s_tuser: cmd.
  input  logic [1:0]   s_tuser,
  // s_tdata: bone_id, time_value, in_pos_x, in_pos_y, in_pos_z,
  //          in_rot_x, in_rot_y, in_rot_z, in_rot_w, then zero fill.
  input  logic [199:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_tuser: found.
  output logic         m_tuser,
  // m_tdata: out_pos_x, out_pos_y, out_pos_z, out_rot_x, out_rot_y,
  //          out_rot_z, out_rot_w.
  output logic [159:0] m_tdata
);

  localparam int unsigned AW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned CW  = $clog2(MAX_KEYS + 1);
  localparam int unsigned TW  = kflt_pkg::TIME_W;
  localparam int unsigned PW  = kflt_pkg::POS_W;
  localparam int unsigned RW  = kflt_pkg::ROT_W;
  localparam int unsigned BW  = kflt_pkg::BONE_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_LO_RD, S_LO_WAIT, S_DIV, S_BLEND,
    S_BLEND_WAIT, S_OUT
  } state_t;

  // Input unpacking.
  logic [1:0]              in_cmd;
  logic [BW-1:0]           in_bone;
  logic [TW-1:0]           in_time;
  kflt_pkg::key_t          in_key;

  assign in_cmd        = s_tuser;
  assign in_bone       = s_tdata[5:0];
  assign in_time       = s_tdata[37:6];
  assign in_key.tval   = s_tdata[37:6];
  assign in_key.pos_x  = s_tdata[69:38];
  assign in_key.pos_y  = s_tdata[101:70];
  assign in_key.pos_z  = s_tdata[133:102];
  assign in_key.rot_x  = s_tdata[149:134];
  assign in_key.rot_y  = s_tdata[165:150];
  assign in_key.rot_z  = s_tdata[181:166];
  assign in_key.rot_w  = s_tdata[197:182];

  state_t                  state;
  logic [CW-1:0]           key_count;
  logic [CW-1:0]           idx;
  logic [AW-1:0]           prev;
  logic                    have_prev;
  logic [BW-1:0]           q_bone;
  logic [TW-1:0]           q_time;
  kflt_pkg::key_t          hi_key;
  kflt_pkg::key_t          lo_key;
  logic [2:0]              comp;
  logic [kflt_pkg::FRAC_W-1:0] frac;
  logic                    found;
  logic [PW-1:0]           res_pos [3];
  logic [RW-1:0]           res_rot [4];
  logic                    out_found;
  logic [PW-1:0]           out_pos [3];
  logic [RW-1:0]           out_rot [4];
  logic                    out_load;

  // Key store: one record per key.
  kflt_pkg::key_t          key_mem [MAX_KEYS];
  logic [BW-1:0]           bone_mem [MAX_KEYS];
  kflt_pkg::key_t          rd_key;
  logic [BW-1:0]           rd_bone;
  logic [AW-1:0]           rd_addr;
  logic                    wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[key_count[AW-1:0]]  <= in_key;
      bone_mem[key_count[AW-1:0]] <= in_bone;
    end
    rd_key  <= key_mem[rd_addr];
    rd_bone <= bone_mem[rd_addr];
  end

  kflt_pkg::div_req_t      dreq;
  kflt_pkg::div_rsp_t      drsp;
  logic signed [PW-1:0]    bl_a, bl_b, bl_y;

  assign s_tready = (state == S_IDLE);
  assign wr_en = s_tvalid && s_tready && in_cmd == kflt_pkg::CMD_APPEND &&
                 32'(in_bone) < BONE_ID_LIMIT && 32'(key_count) < MAX_KEYS;
  assign rd_addr = (state == S_LO_RD) ? prev : idx[AW-1:0];
  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  // The earlier key sits on the read port during S_LO_WAIT.
  assign dreq.start = (state == S_LO_WAIT) && have_prev;
  assign dreq.num   = q_time - rd_key.tval;
  assign dreq.den   = hi_key.tval - rd_key.tval;

  kflt_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  always_comb begin
    unique case (comp)
      3'd0: begin bl_a = lo_key.pos_x; bl_b = hi_key.pos_x; end
      3'd1: begin bl_a = lo_key.pos_y; bl_b = hi_key.pos_y; end
      3'd2: begin bl_a = lo_key.pos_z; bl_b = hi_key.pos_z; end
      3'd3: begin bl_a = PW'($signed(lo_key.rot_x)); bl_b = PW'($signed(hi_key.rot_x)); end
      3'd4: begin bl_a = PW'($signed(lo_key.rot_y)); bl_b = PW'($signed(hi_key.rot_y)); end
      3'd5: begin bl_a = PW'($signed(lo_key.rot_z)); bl_b = PW'($signed(hi_key.rot_z)); end
      3'd6: begin bl_a = PW'($signed(lo_key.rot_w)); bl_b = PW'($signed(hi_key.rot_w)); end
      default: begin bl_a = '0; bl_b = '0; end
    endcase
  end

  kflt_blend u_blend (.clk(clk), .a(bl_a), .b(bl_b), .frac(frac), .y(bl_y));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      key_count <= '0;
      found     <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid  <= 1'b1;
        out_found <= found;
        for (int k = 0; k < 3; k++) out_pos[k] <= res_pos[k];
        for (int k = 0; k < 4; k++) out_rot[k] <= res_rot[k];
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            q_bone    <= in_bone;
            q_time    <= in_time;
            idx       <= '0;
            have_prev <= 1'b0;
            prev      <= '0;
            found     <= 1'b0;
            for (int k = 0; k < 3; k++) res_pos[k] <= '0;
            for (int k = 0; k < 4; k++) res_rot[k] <= '0;
            if (in_cmd == kflt_pkg::CMD_CLEAR) begin
              key_count <= '0;
            end else if (wr_en) begin
              key_count <= key_count + 1'b1;
            end else if (in_cmd == kflt_pkg::CMD_QUERY) begin
              state <= (32'(in_bone) < BONE_ID_LIMIT) ? S_SCAN_RD : S_OUT;
            end
          end
        end
        S_SCAN_RD: begin
          state <= (idx < key_count) ? S_SCAN_CHK : S_OUT;
        end
        S_SCAN_CHK: begin
          if (rd_bone == q_bone && q_time < rd_key.tval) begin
            hi_key <= rd_key;
            state  <= S_LO_RD;
          end else begin
            if (rd_bone == q_bone) begin
              have_prev <= 1'b1;
              prev      <= idx[AW-1:0];
            end
            idx   <= idx + 1'b1;
            state <= S_SCAN_RD;
          end
        end
        S_LO_RD: begin
          state <= S_LO_WAIT;
        end
        S_LO_WAIT: begin
          lo_key <= have_prev ? rd_key : hi_key;
          frac   <= '0;
          comp   <= '0;
          state  <= have_prev ? S_DIV : S_BLEND;
        end
        S_DIV: begin
          if (drsp.done) begin
            frac  <= drsp.quo;
            state <= S_BLEND;
          end
        end
        S_BLEND: begin
          state <= S_BLEND_WAIT;
        end
        S_BLEND_WAIT: begin
          if (comp < 3'd3) res_pos[comp[1:0]] <= bl_y;
          else res_rot[2'(comp - 3'd3)] <= bl_y[RW-1:0];
          if (comp == 3'd6) begin
            found <= 1'b1;
            state <= S_OUT;
          end else begin
            comp  <= comp + 1'b1;
            state <= S_BLEND;
          end
        end
        S_OUT: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tuser = out_found;
  assign m_tdata = {out_rot[3], out_rot[2], out_rot[1], out_rot[0],
                    out_pos[2], out_pos[1], out_pos[0]};

  property p_count_bound;
    @(posedge clk) disable iff (rst) 32'(key_count) <= MAX_KEYS;
  endproperty
  a_count_bound: assert property (p_count_bound) else $error("key count overflow");

  property p_div_in_div;
    @(posedge clk) disable iff (rst) drsp.done |-> state == S_DIV;
  endproperty
  a_div_in_div: assert property (p_div_in_div) else $error("divider done out of place");

  property p_no_write_busy;
    @(posedge clk) disable iff (rst) wr_en |-> state == S_IDLE;
  endproperty
  a_no_write_busy: assert property (p_no_write_busy) else $error("write while busy");

  property p_out_hold;
    @(posedge clk) disable iff (rst)
      m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser);
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result beat changed while stalled");

endmodule

// ===== design/kflt_div.sv =====
// ---------------------------------------------------------------------------
// kflt_div: serial restoring divider for the interpolation fraction
// Computes floor((num << 16) / den) with num < den, one bit per cycle.
// ---------------------------------------------------------------------------
module kflt_div (
  input  logic               clk,
  input  logic               rst,
  input  kflt_pkg::div_req_t req,
  output kflt_pkg::div_rsp_t rsp
);

  localparam int unsigned CNT_W = $clog2(kflt_pkg::FRAC_W + 1);

  logic [kflt_pkg::TIME_W:0]     rem;
  logic [kflt_pkg::TIME_W-1:0]   den;
  logic [kflt_pkg::FRAC_W-1:0]   quo;
  logic [CNT_W-1:0]              cnt;
  logic                          busy;
  logic                          done;
  logic [kflt_pkg::TIME_W+1:0]   trial;
  logic [kflt_pkg::TIME_W:0]     shifted;

  always_comb begin
    shifted = {rem[kflt_pkg::TIME_W-1:0], 1'b0};
    trial   = {1'b0, shifted} - {2'b00, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem  <= {1'b0, req.num};
        den  <= req.den;
        quo  <= '0;
        cnt  <= CNT_W'(kflt_pkg::FRAC_W);
        busy <= 1'b1;
      end else if (busy) begin
        if (!trial[kflt_pkg::TIME_W+1]) begin
          rem <= trial[kflt_pkg::TIME_W:0];
          quo <= {quo[kflt_pkg::FRAC_W-2:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[kflt_pkg::FRAC_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

  property p_busy_count;
    @(posedge clk) disable iff (rst) busy |-> cnt != '0;
  endproperty
  a_busy_count: assert property (p_busy_count) else $error("divider busy with zero count");

  property p_done_after_busy;
    @(posedge clk) disable iff (rst) done |-> $past(busy);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy) else $error("done without busy");

  property p_no_start_busy;
    @(posedge clk) disable iff (rst) req.start |=> busy;
  endproperty
  a_no_start_busy: assert property (p_no_start_busy) else $error("start did not set busy");

endmodule

// ===== design/kflt_blend.sv =====
// ---------------------------------------------------------------------------
// kflt_blend: shared lerp unit
// Computes floor((a*(65536-f) + b*f + 32768) / 65536) as a + round((b-a)*f),
// one component per call, registered after the multiply.
// ---------------------------------------------------------------------------
module kflt_blend (
  input  logic                          clk,
  input  logic signed [kflt_pkg::POS_W-1:0] a,
  input  logic signed [kflt_pkg::POS_W-1:0] b,
  input  logic [kflt_pkg::FRAC_W-1:0]   frac,
  output logic signed [kflt_pkg::POS_W-1:0] y
);

  localparam int unsigned DW = kflt_pkg::POS_W + 1;
  localparam int unsigned PW = DW + kflt_pkg::FRAC_W + 1;

  logic signed [DW-1:0]            diff;
  logic signed [PW-1:0]            prod;
  logic signed [kflt_pkg::POS_W-1:0] a_q;
  logic signed [PW-1:0]            sum;

  assign diff = DW'(b) - DW'(a);

  always_ff @(posedge clk) begin
    prod <= PW'(diff) * $signed({1'b0, frac});
    a_q  <= a;
  end

  // a*65536 + (b-a)*f + 32768, arithmetic shift right by 16.
  assign sum = (PW'(a_q) <<< kflt_pkg::FRAC_W) + prod + PW'(32768);
  assign y   = kflt_pkg::POS_W'(sum >>> kflt_pkg::FRAC_W);

endmodule
